// ===== rtl/lcd_segment_frame_encoder_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LCD_SEGMENT_FRAME_ENCODER_ASSERT_SVH
`define LCD_SEGMENT_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCDSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcdsf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCDSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcdsf assertion failed");

`endif

// ===== rtl/lcdsf_pkg.sv =====
`timescale 1ns / 1ps

package lcdsf_pkg;

    localparam int FrameLen = 7;

    typedef logic [FrameLen-1:0][7:0] t_frame;

    typedef struct packed {
        logic               link_connected;
        logic [2:0]         smiley_code;
        logic [2:0]         unit_symbol;
        logic [7:0]         battery_level;
        logic               percent_mark;
        logic signed [15:0] small_value;
        logic signed [15:0] big_value_x10;
    } t_item;

    localparam logic [7:0] SymH    = 8'h76;
    localparam logic [7:0] SymI    = 8'h40;
    localparam logic [7:0] SymL    = 8'h58;
    localparam logic [7:0] SymO    = 8'h6C;
    localparam logic [7:0] SymZero = 8'h5F;

    function automatic logic [7:0] digit_seg(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = SymZero;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h6B;
            4'd3:    seg = 8'h2F;
            4'd4:    seg = 8'h36;
            4'd5:    seg = 8'h3D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h3F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/lcd_segment_frame_encoder.sv =====
`timescale 1ns / 1ps
// Throughput: one input transaction per cycle unless a changed frame meets a stalled master
// side; the encode pass sits between the input register and the last-sent frame register,
// which also drives the output.
// Reset: display enabled, no transaction pending, last-sent frame all zero,
// units byte of the large field set to the letter o.

module lcd_segment_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] big_value_x10, [31:16] small_value, [32] percent_mark,
    // [40:33] battery_level, [43:41] unit_symbol, [46:44] smiley_code,
    // [47] link_connected
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] seg_byte0, [15:8] seg_byte1, [23:16] seg_byte2, [31:24] seg_byte3,
    // [39:32] seg_byte4, [47:40] seg_byte5, [55:48] seg_byte6
    output logic [55:0] o_m_axis_tdata
);
    import lcdsf_pkg::*;

    logic       r_display_off;
    logic       n_display_off;
    logic       r_in_valid;
    logic       n_in_valid;
    t_item      r_item;
    logic [7:0] r_byte2;
    logic [7:0] n_byte2;
    t_frame     r_last_sent;
    t_frame     n_last_sent;
    logic       r_out_valid;
    logic       n_out_valid;

    t_frame     frame_enc;
    logic       emit;
    logic       out_free;
    logic       advance;
    logic       in_fire;

    lcdsf_encode u_encode (
        .i_item       (r_item),
        .i_prev_byte2 (r_byte2),
        .o_frame      (frame_enc)
    );

    assign emit            = !r_display_off && (frame_enc != r_last_sent);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && (!emit || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_last_sent;

    always_comb begin
        n_display_off = i_cfg_we ? i_cfg_wdata : r_display_off;

        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end

        n_byte2 = advance ? frame_enc[2] : r_byte2;

        if (advance && emit) begin
            n_last_sent = frame_enc;
            n_out_valid = 1'b1;
        end else begin
            n_last_sent = r_last_sent;
            n_out_valid = r_out_valid && !i_m_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_off <= 1'b0;
            r_in_valid    <= 1'b0;
            r_byte2       <= SymO;
            r_last_sent   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_display_off <= n_display_off;
            r_in_valid    <= n_in_valid;
            r_byte2       <= n_byte2;
            r_last_sent   <= n_last_sent;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= t_item'(i_s_axis_tdata);
        end
    end

endmodule

// ===== rtl/lcdsf_encode.sv =====
`timescale 1ns / 1ps

module lcdsf_encode (
    input  lcdsf_pkg::t_item  i_item,
    input  logic [7:0]        i_prev_byte2,
    output lcdsf_pkg::t_frame o_frame
);
    import lcdsf_pkg::*;

    localparam logic signed [15:0] BigHi    = 16'sd19995;
    localparam logic signed [15:0] BigLo    = -16'sd995;
    localparam logic signed [15:0] BigRndHi = 16'sd1995;
    localparam logic signed [15:0] BigRndLo = -16'sd95;
    localparam logic signed [15:0] SmlHi    = 16'sd99;
    localparam logic signed [15:0] SmlLo    = -16'sd9;

    // floor(x * R >> S) equals x / D for every x below 21000
    localparam logic [14:0] Recip10   = 15'd26215;
    localparam logic [12:0] Recip100  = 13'd5243;
    localparam logic [13:0] Recip1000 = 14'd8389;
    localparam logic [7:0]  RecipSml  = 8'd205;

    logic signed [15:0] big;
    logic signed [15:0] sml;
    logic               big_hi;
    logic               big_lo;
    logic               big_neg;
    logic               big_rnd;
    logic [15:0]        big_mag;
    logic [14:0]        x;
    logic [29:0]        p10;
    logic [27:0]        p100;
    logic [28:0]        p1000;
    logic [10:0]        d10;
    logic [7:0]         d100;
    logic [4:0]         d1000;
    logic [10:0]        m_val;
    logic [7:0]         t_val;
    logic [4:0]         h_val;
    logic [3:0]         big_units;
    logic [3:0]         big_tens;
    logic [3:0]         big_hund;
    logic               sml_hi;
    logic               sml_lo;
    logic               sml_neg;
    logic [6:0]         sml_mag;
    logic [14:0]        sp;
    logic [3:0]         sml_tens;
    logic [3:0]         sml_units;
    logic [7:0]         link_bit;

    always_comb begin
        big     = i_item.big_value_x10;
        big_hi  = big > BigHi;
        big_lo  = big < BigLo;
        big_neg = big < 16'sd0;
        big_rnd = (big > BigRndHi) || (big < BigRndLo);
        big_mag = big_neg ? 16'(-big) : 16'(big);

        // rounded case: digits of (mag + 5) / 10 are taken from (mag + 5) one decade up
        x     = big_rnd ? 15'(big_mag + 16'd5) : big_mag[14:0];
        p10   = 30'(x) * 30'(Recip10);
        p100  = 28'(x) * 28'(Recip100);
        p1000 = 29'(x) * 29'(Recip1000);
        d10   = p10[28:18];
        d100  = p100[26:19];
        d1000 = p1000[27:23];

        m_val = big_rnd ? d10 : x[10:0];
        t_val = big_rnd ? d100 : d10[7:0];
        h_val = big_rnd ? d1000 : d100[4:0];

        big_units = 4'(m_val - 11'(t_val) * 11'd10);
        big_tens  = 4'(t_val - 8'(h_val) * 8'd10);
        if (h_val >= 5'd20) begin
            big_hund = 4'(h_val - 5'd20);
        end else if (h_val >= 5'd10) begin
            big_hund = 4'(h_val - 5'd10);
        end else begin
            big_hund = h_val[3:0];
        end

        sml       = i_item.small_value;
        sml_hi    = sml > SmlHi;
        sml_lo    = sml < SmlLo;
        sml_neg   = sml < 16'sd0;
        sml_mag   = sml_neg ? 7'(-sml) : 7'(sml);
        sp        = 15'(sml_mag) * 15'(RecipSml);
        sml_tens  = sp[14:11];
        sml_units = 4'(sml_mag - 7'(sml_tens) * 7'd10);

        link_bit = {i_item.link_connected, 7'b0};

        if (big_hi) begin
            o_frame[0] = SymH;
            o_frame[1] = SymI | link_bit;
            o_frame[2] = i_prev_byte2;
        end else if (big_lo) begin
            o_frame[0] = SymL;
            o_frame[1] = SymO | link_bit;
            o_frame[2] = i_prev_byte2;
        end else begin
            o_frame[0] = (big_neg ? 8'h20 : 8'h00)
                       | ((h_val >= 5'd10) ? 8'h80 : 8'h00)
                       | ((h_val != 5'd0) ? digit_seg(big_hund) : 8'h00);
            o_frame[1] = digit_seg(big_tens) | link_bit;
            o_frame[2] = (big_rnd ? 8'h00 : 8'h80) | digit_seg(big_units);
        end

        o_frame[3] = {i_item.battery_level > 8'd20, i_item.battery_level > 8'd40,
                      i_item.battery_level > 8'd60, i_item.battery_level > 8'd80,
                      i_item.unit_symbol[1], i_item.unit_symbol[0],
                      i_item.unit_symbol[2], 1'b1};

        if (sml_hi) begin
            o_frame[4] = {i_item.smiley_code[2], 7'b0} | SymH;
            o_frame[5] = {i_item.percent_mark, 7'b0} | SymI;
        end else if (sml_lo) begin
            o_frame[4] = {i_item.smiley_code[2], 7'b0} | SymL;
            o_frame[5] = {i_item.percent_mark, 7'b0} | SymO;
        end else begin
            o_frame[4] = {i_item.smiley_code[2], 7'b0}
                       | (sml_neg ? 8'h04 : 8'h00)
                       | ((sml_mag > 7'd9) ? digit_seg(sml_tens) : 8'h00);
            o_frame[5] = {i_item.percent_mark, 7'b0} | digit_seg(sml_units);
        end

        o_frame[6] = {i_item.smiley_code[1:0], 6'b0};
    end

endmodule

// ===== rtl/lcdsf_checker.sv =====
`timescale 1ns / 1ps
`include "lcd_segment_frame_encoder_assert.svh"

module lcdsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata
);

    logic        r_seen;
    logic [55:0] r_last_out;
    logic        out_fire;

    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_fire) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_last_out <= o_m_axis_tdata;
        end
    end

    `LCDSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))

    `LCDSF_ASSERT_NOW(a_no_repeat, i_clk, i_rst_n, out_fire && r_seen,
        o_m_axis_tdata != r_last_out)

    `LCDSF_ASSERT_NOW(a_outline_lit, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[24])

    `LCDSF_ASSERT_NOW(a_reset_idle, i_clk, i_rst_n, $past(!i_rst_n),
        !o_m_axis_tvalid && o_s_axis_tready)

endmodule

bind lcd_segment_frame_encoder lcdsf_checker u_lcdsf_checker (.*);
